// ----- src/stmin_pkg.sv -----
// Shared constants and helpers for the segment tree range-minimum block.
// No dependencies; imported by segment_tree_range_min_top.
package stmin_pkg;

  // Field widths of the input and result beats
  localparam int VAL_W = 32;
  localparam int IDX_W = 10;

  // Default number of leaves (power of two)
  localparam int LEAVES_DEF = 1024;

  // Neutral start value of the query minimum
  localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7fff_ffff;

  // Item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Signed minimum of two values
  function automatic logic signed [VAL_W-1:0] min2(input logic signed [VAL_W-1:0] x,
                                                   input logic signed [VAL_W-1:0] y);
    return (x < y) ? x : y;
  endfunction

endpackage

// ----- src/segment_tree_range_min_top.sv -----
// Range-minimum segment tree: tree memory, load update walk and query walk.
// Depends on stmin_pkg.
// Reset: synchronous; a clearing pass writes zero to all 2*LEAVES tree entries,
//   and in_ready is low during the pass.
// Load: the leaf is written first, then the ancestor walk reads one sibling and
//   writes one parent per cycle up to the root.
// Query: the walk folds one tree level per cycle on two read ports; an empty
//   range gives its result without a walk.
// One item at a time; the result register lets the next item in while it waits.
module segment_tree_range_min_top #(
  parameter int LEAVES = stmin_pkg::LEAVES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                mode,
  input  logic        [stmin_pkg::IDX_W-1:0]  leaf_index,
  input  logic signed [stmin_pkg::VAL_W-1:0]  leaf_value,
  input  logic        [stmin_pkg::IDX_W-1:0]  query_lo,
  input  logic        [stmin_pkg::IDX_W-1:0]  query_hi,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [stmin_pkg::VAL_W-1:0]  min_value,
  output logic                                range_error
);
  import stmin_pkg::*;

  localparam int LW    = $clog2(LEAVES);
  localparam int NA    = LW + 1;       // tree memory address width
  localparam int AW    = LW + 2;       // query pointer width, holds 2*LEAVES
  localparam int DEPTH = 2 * LEAVES;

  typedef enum logic [5:0] {
    ST_CLR  = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_LD   = 6'b000100,
    ST_LU   = 6'b001000,
    ST_QW   = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state;

  logic [NA-1:0]            clr_cnt;
  logic [NA-1:0]            node;
  logic signed [VAL_W-1:0]  cur;
  logic [AW-1:0]            qa;
  logic [AW-1:0]            qb;
  logic signed [VAL_W-1:0]  best;
  logic                     pend_a;
  logic                     pend_b;
  logic signed [VAL_W-1:0]  res_val;
  logic                     res_err;

  logic                     mem_we;
  logic [NA-1:0]            mem_waddr;
  logic signed [VAL_W-1:0]  mem_wdata;
  logic [NA-1:0]            rd_a_addr;
  logic [NA-1:0]            rd_b_addr;
  logic signed [VAL_W-1:0]  rd_a;
  logic signed [VAL_W-1:0]  rd_b;

  logic [NA-1:0]            parent;
  logic signed [VAL_W-1:0]  lu_min;
  logic [AW-1:0]            qb_m1;
  logic                     q_live;
  logic signed [VAL_W-1:0]  fold_a;
  logic signed [VAL_W-1:0]  fold;
  logic [IDX_W-1:0]         li_m;
  logic [IDX_W-1:0]         lo_m;
  logic [IDX_W-1:0]         hi_m;
  logic                     out_free;
  logic                     in_beat;

  // Indexes wrap to the leaf count
  assign li_m = leaf_index & IDX_W'(LEAVES - 1);
  assign lo_m = query_lo & IDX_W'(LEAVES - 1);
  assign hi_m = query_hi & IDX_W'(LEAVES - 1);

  assign in_ready = (state == ST_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Update walk: combine with the sibling just read
  assign parent = node >> 1;
  assign lu_min = min2(cur, rd_a);

  // Query walk: fold reads issued in the previous cycle
  assign q_live = (qa < qb);
  assign qb_m1  = qb - AW'(1);
  assign fold_a = min2(best, pend_a ? rd_a : INT_MAX);
  assign fold   = min2(fold_a, pend_b ? rd_b : INT_MAX);

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = node;
    mem_wdata = cur;
    rd_a_addr = qa[NA-1:0];
    rd_b_addr = qb_m1[NA-1:0];
    case (state)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      ST_LD: begin
        mem_we    = 1'b1;
        mem_waddr = node;
        mem_wdata = cur;
        rd_a_addr = node ^ NA'(1);
      end
      ST_LU: begin
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = lu_min;
        rd_a_addr = parent ^ NA'(1);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Tree memory: one write port, two registered read ports
  logic signed [VAL_W-1:0] tree_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tree_mem[mem_waddr] <= mem_wdata;
    end
    rd_a <= tree_mem[rd_a_addr];
    rd_b <= tree_mem[rd_b_addr];
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLR;
      clr_cnt <= '0;
    end else begin
      case (state)
        ST_CLR: begin
          clr_cnt <= clr_cnt + NA'(1);
          if (clr_cnt == NA'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_beat) begin
            if (mode == MODE_LOAD) begin
              state <= ST_LD;
            end else if (lo_m > hi_m) begin
              state <= ST_DONE;
            end else begin
              state <= ST_QW;
            end
          end
        end
        ST_LD: begin
          state <= ST_LU;
        end
        ST_LU: begin
          if (parent == NA'(1)) begin
            state <= ST_IDLE;
          end
        end
        ST_QW: begin
          if (!q_live) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLR;
        end
      endcase
    end
  end

  // Walk datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_beat) begin
          node    <= NA'(LEAVES) + NA'(li_m);
          cur     <= leaf_value;
          qa      <= AW'(LEAVES) + AW'(lo_m);
          qb      <= AW'(LEAVES) + AW'(hi_m) + AW'(1);
          best    <= INT_MAX;
          pend_a  <= 1'b0;
          pend_b  <= 1'b0;
          res_val <= '0;
          res_err <= 1'b1;
        end
      end
      ST_LU: begin
        node <= parent;
        cur  <= lu_min;
      end
      ST_QW: begin
        best   <= fold;
        pend_a <= q_live && qa[0];
        pend_b <= q_live && qb[0];
        qa     <= (qa + AW'(qa[0])) >> 1;
        qb     <= (qb - AW'(qb[0])) >> 1;
        if (!q_live) begin
          res_val <= fold;
          res_err <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      min_value   <= res_val;
      range_error <= res_err;
    end
  end

  // Checks
  a_clr_after_rst: assert property (@(posedge clk)
    rst |=> (state == ST_CLR) && (clr_cnt == '0))
    else $error("clearing pass did not restart after reset");

  a_walk_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LD || state == ST_LU) |-> (mem_waddr != rd_a_addr))
    else $error("update walk reads the entry it writes");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && range_error) |-> (min_value == '0))
    else $error("empty range result is not zero");

  a_qb_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QW) |-> (qb <= AW'(DEPTH)))
    else $error("query right pointer out of range");

  a_no_beat_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LD) |-> $past(in_valid) && $past(mode == MODE_LOAD))
    else $error("load walk started without a load beat");

endmodule
